// ===== rtl/round_robin_port_allocator_unit_macros.svh =====
// Assertion helpers shared by the allocator RTL.
// Every check is clocked on clk and held off while arst_n is low.
`ifndef ROUND_ROBIN_PORT_ALLOCATOR_UNIT_MACROS_SVH
`define ROUND_ROBIN_PORT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define RRPA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrpa: same-cycle check failed");

// Next-cycle implication
`define RRPA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrpa: next-cycle check failed");

`endif

// ===== rtl/rrpa_pkg.sv =====
package rrpa_pkg;

	// Bitmap word geometry: 32 port bits per memory row
	localparam int WORD_LG   = 5;
	localparam int WORD_BITS = 1 << WORD_LG;

	// Stream field widths
	localparam int PORT_W      = 16;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_FIELD_W = STATUS_W + 1 + PORT_W;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EPHEM  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_IN_USE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_AGAIN  = 2'd2;

	// Configuration register indexes
	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_LAST  = 1'b1;

	// Register reset values
	localparam logic [PORT_W-1:0] FIRST_RESET = 16'd49152;
	localparam logic [PORT_W-1:0] LAST_RESET  = 16'd65535;

	// First free port found in one bitmap row
	typedef struct packed {
		logic               hit;
		logic [WORD_LG-1:0] idx;
	} rrpa_hit_t;

endpackage

// ===== rtl/round_robin_port_allocator_unit.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: kind; tdata: port_number
// m_*       out  m_tvalid/m_tready  tdata: status, found, granted_port
// cfg_*     in   cfg_valid/ready    cfg_index, cfg_data
//
// Lookup, allocate and free go through accept with row read, modify and
// write back, then the result register. Ephemeral allocation goes through
// accept, range set-up, then one read and one check per 32-port bitmap row the
// scan visits (an inverted range goes from set-up straight to the result).
// After reset the bitmap is swept clear, row by row, with s_tready low.
// One item is in flight; a result held by m_tready low stalls the next one.
`include "round_robin_port_allocator_unit_macros.svh"

module round_robin_port_allocator_unit
	import rrpa_pkg::*;
#(
	parameter int PORT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [15:0] port_number
	input  logic [KIND_W-1:0]      s_tuser,  // [1:0] kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [1:0] status, [2] found, [18:3] granted_port
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [PORT_W-1:0]      cfg_data
);

	localparam int PB = PORT_BITS;
	localparam int RB = PORT_BITS - WORD_LG;

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_RMW      = 3'd2;
	localparam logic [2:0] ST_EPH      = 3'd3;
	localparam logic [2:0] ST_SCAN_RD  = 3'd4;
	localparam logic [2:0] ST_SCAN_CHK = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	logic [2:0]          state_q;
	logic [RB-1:0]       clr_q;
	logic [KIND_W-1:0]   kind_q;
	logic [PB-1:0]       port_q;
	logic [PB-1:0]       first_q, last_q, cursor_q, start_q;
	logic [RB-1:0]       scan_row_q;
	logic                wrap_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_found_q;
	logic [PB-1:0]       res_port_q;

	logic                 in_accept, out_load;
	logic                 rd_en, wr_en;
	logic [RB-1:0]        rd_row, wr_row;
	logic [WORD_BITS-1:0] rd_word, wr_word;
	logic [WORD_LG-1:0]   port_bit;
	logic                 cur_bit, port_zero;
	logic [PB-1:0]        seg_lo, seg_hi;
	rrpa_hit_t            hit;
	logic [PB-1:0]        found_port, next_cursor, start_val;
	logic                 cur_in_range;
	logic [RB-1:0]        end_row;

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign in_accept = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	// Bitmap read address: request row on accept, scan row while searching
	assign rd_en  = in_accept || (state_q == ST_SCAN_RD);
	assign rd_row = (state_q == ST_SCAN_RD) ? scan_row_q : s_tdata[PB-1:WORD_LG];

	assign port_bit  = port_q[WORD_LG-1:0];
	assign cur_bit   = rd_word[port_bit];
	assign port_zero = port_q == PB'(0);

	// Scan segment: cursor up to last, then first up to just below cursor
	assign seg_lo  = wrap_q ? first_q : start_q;
	assign seg_hi  = wrap_q ? (start_q - PB'(1)) : last_q;
	assign end_row = seg_hi[PB-1:WORD_LG];

	assign cur_in_range = (cursor_q >= first_q) && (cursor_q <= last_q);
	assign start_val    = cur_in_range ? cursor_q : first_q;
	assign found_port   = {scan_row_q, hit.idx};
	assign next_cursor  = (found_port == last_q) ? first_q : (found_port + PB'(1));

	rrpa_bitmap_ram #(
		.ROW_BITS(RB)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_word (rd_word),
		.wr_en   (wr_en),
		.wr_row  (wr_row),
		.wr_word (wr_word)
	);

	rrpa_word_scan #(
		.PORT_BITS(PB)
	) u_scan (
		.word   (rd_word),
		.row    (scan_row_q),
		.seg_lo (seg_lo),
		.seg_hi (seg_hi),
		.result (hit)
	);

	// Write-back: clear sweep, bind/unbind, or bind the scan hit
	always_comb begin
		wr_en   = 1'b0;
		wr_row  = port_q[PB-1:WORD_LG];
		wr_word = rd_word;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_row  = clr_q;
				wr_word = '0;
			end
			ST_RMW: begin
				if (kind_q == KIND_ALLOC && !port_zero && !cur_bit) begin
					wr_en             = 1'b1;
					wr_word[port_bit] = 1'b1;
				end else if (kind_q == KIND_FREE && !port_zero) begin
					wr_en             = 1'b1;
					wr_word[port_bit] = 1'b0;
				end
			end
			ST_SCAN_CHK: begin
				if (hit.hit) begin
					wr_en            = 1'b1;
					wr_row           = scan_row_q;
					wr_word[hit.idx] = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= PB'(FIRST_RESET);
			last_q  <= PB'(LAST_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIRST: first_q <= cfg_data[PB-1:0];
				CFG_LAST:  last_q  <= cfg_data[PB-1:0];
				default:   first_q <= first_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			cursor_q <= PB'(FIRST_RESET);
			wrap_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + RB'(1);
					if (clr_q == {RB{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= (s_tuser == KIND_EPHEM) ? ST_EPH : ST_RMW;
					end
				end
				ST_RMW: begin
					state_q <= ST_DONE;
				end
				ST_EPH: begin
					wrap_q <= 1'b0;
					state_q <= (first_q > last_q) ? ST_DONE : ST_SCAN_RD;
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (hit.hit) begin
						cursor_q <= next_cursor;
						state_q  <= ST_DONE;
					end else if (scan_row_q != end_row) begin
						state_q <= ST_SCAN_RD;
					end else if (!wrap_q && start_q != first_q) begin
						wrap_q  <= 1'b1;
						state_q <= ST_SCAN_RD;
					end else begin
						cursor_q <= start_q;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request, scan position and result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q <= s_tuser;
			port_q <= s_tdata[PB-1:0];
		end
		case (state_q)
			ST_RMW: begin
				res_status_q <= STAT_OK;
				res_found_q  <= 1'b0;
				res_port_q   <= '0;
				if (kind_q == KIND_LOOKUP) begin
					res_found_q <= !port_zero && cur_bit;
				end else if (kind_q == KIND_ALLOC) begin
					if (port_zero || cur_bit) begin
						res_status_q <= STAT_IN_USE;
					end else begin
						res_port_q <= port_q;
					end
				end
			end
			ST_EPH: begin
				start_q      <= start_val;
				scan_row_q   <= start_val[PB-1:WORD_LG];
				res_status_q <= STAT_AGAIN;
				res_found_q  <= 1'b0;
				res_port_q   <= '0;
			end
			ST_SCAN_CHK: begin
				if (hit.hit) begin
					res_status_q <= STAT_OK;
					res_port_q   <= found_port;
				end else if (scan_row_q != end_row) begin
					scan_row_q <= scan_row_q + RB'(1);
				end else begin
					scan_row_q <= first_q[PB-1:WORD_LG];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {OUT_PAD_W'(0), PORT_W'(res_port_q), res_found_q, res_status_q};
		end
	end

	`RRPA_ASSERT_IMP(a_no_accept_in_clear, state_q == ST_CLEAR, !s_tready)
	`RRPA_ASSERT_IMP(a_no_write_when_idle, wr_en, state_q != ST_IDLE && state_q != ST_DONE)
	`RRPA_ASSERT_NXT(a_cursor_hold, state_q != ST_SCAN_CHK, $stable(cursor_q))
	`RRPA_ASSERT_IMP(a_grant_means_ok, m_tvalid && m_tdata[18:3] != 16'd0, m_tdata[1:0] == STAT_OK)
	`RRPA_ASSERT_IMP(a_found_only_lookup, m_tvalid && m_tdata[2], m_tdata[18:3] == 16'd0)

endmodule

// ===== rtl/rrpa_bitmap_ram.sv =====
module rrpa_bitmap_ram
	import rrpa_pkg::*;
#(
	parameter int ROW_BITS = 11
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ROW_BITS-1:0]  rd_row,
	output logic [WORD_BITS-1:0] rd_word,
	input  logic                 wr_en,
	input  logic [ROW_BITS-1:0]  wr_row,
	input  logic [WORD_BITS-1:0] wr_word
);

	logic [WORD_BITS-1:0] mem [(1 << ROW_BITS)];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_word;
		end
	end

	// Registered read port, data holds when not read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word <= mem[rd_row];
		end
	end

endmodule

// ===== rtl/rrpa_word_scan.sv =====
module rrpa_word_scan
	import rrpa_pkg::*;
#(
	parameter int PORT_BITS = 16
) (
	input  logic [WORD_BITS-1:0]         word,
	input  logic [PORT_BITS-WORD_LG-1:0] row,
	input  logic [PORT_BITS-1:0]         seg_lo,
	input  logic [PORT_BITS-1:0]         seg_hi,
	output rrpa_hit_t                    result
);

	localparam int RB = PORT_BITS - WORD_LG;

	logic [WORD_BITS-1:0] cand;
	logic                 lo_row, hi_row, zero_row;

	assign lo_row   = row == seg_lo[PORT_BITS-1:WORD_LG];
	assign hi_row   = row == seg_hi[PORT_BITS-1:WORD_LG];
	assign zero_row = row == RB'(0);

	// Free bits inside the segment; port zero never qualifies
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			cand[b] = !word[b]
				&& (!lo_row || (WORD_LG'(b) >= seg_lo[WORD_LG-1:0]))
				&& (!hi_row || (WORD_LG'(b) <= seg_hi[WORD_LG-1:0]))
				&& (!zero_row || (b != 0));
		end
	end

	// Lowest candidate wins
	always_comb begin
		result.hit = |cand;
		result.idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				result.idx = WORD_LG'(b);
			end
		end
	end

endmodule

// ===== dv/tb_round_robin_port_allocator_unit.sv =====
module tb_round_robin_port_allocator_unit;
	import rrpa_pkg::*;

	localparam int HOLD_CYCLES = 300;

	// Expected outcome of one request
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [PORT_W-1:0]   granted;
	} alloc_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [KIND_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_index;
	logic [PORT_W-1:0]      cfg_data;

	// Allocator state as the block should hold it
	bit                bound_map [0:(1 << PORT_W) - 1];
	logic [PORT_W-1:0] next_ephem;
	logic [PORT_W-1:0] eph_first;
	logic [PORT_W-1:0] eph_last;
	logic [PORT_W-1:0] recent_ports [$];

	alloc_result_t pending_results [$];
	int            mismatch_count;
	int            send_idle_pct;
	int            recv_stall_pct;
	int            hold_seq;
	int            hold_seen;
	int            hold_left;

	round_robin_port_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_round_robin_port_allocator_unit: errors");
		$finish;
	end

	// Round-robin search from the cursor through the ephemeral range
	function automatic alloc_result_t scan_ephemeral();
		alloc_result_t r;
		logic [PORT_W-1:0] cur;
		logic [PORT_W-1:0] start;
		logic [PORT_W-1:0] p;
		bit done;
		r = '0;
		done = 1'b0;
		if (eph_first > eph_last) begin
			r.status = STAT_AGAIN;
			return r;
		end
		cur = next_ephem;
		if (cur < eph_first || cur > eph_last)
			cur = eph_first;
		start = cur;
		do begin
			p = cur;
			cur = (cur == eph_last) ? eph_first : cur + 1'b1;
			if (p != '0 && !bound_map[p]) begin
				bound_map[p] = 1'b1;
				next_ephem = cur;
				r.granted = p;
				done = 1'b1;
			end
		end while (!done && cur != start);
		if (!done) begin
			// range full: cursor goes back to where the scan began
			next_ephem = start;
			r.status = STAT_AGAIN;
		end
		return r;
	endfunction

	// Outcome of one request, updating the mirrored state
	function automatic alloc_result_t allocate_outcome(input logic [KIND_W-1:0] kind,
			input logic [PORT_W-1:0] port);
		alloc_result_t r;
		r = '0;
		case (kind)
			KIND_LOOKUP: begin
				r.found = (port != '0) && bound_map[port];
			end
			KIND_ALLOC: begin
				if (port == '0 || bound_map[port]) begin
					r.status = STAT_IN_USE;
				end else begin
					bound_map[port] = 1'b1;
					r.granted = port;
				end
			end
			KIND_EPHEM: begin
				r = scan_ephemeral();
			end
			default: begin
				if (port != '0)
					bound_map[port] = 1'b0;
			end
		endcase
		if (r.granted != '0) begin
			recent_ports.push_back(r.granted);
			if (recent_ports.size() > 64)
				void'(recent_ports.pop_front());
		end
		return r;
	endfunction

	// Port choice: near the range, a recently granted one, or anywhere
	function automatic logic [PORT_W-1:0] pick_port();
		int sel;
		int span;
		sel = $urandom_range(99);
		span = (eph_last >= eph_first) ? int'(eph_last - eph_first) : 4;
		if (sel < 45)
			return eph_first + PORT_W'($urandom_range(span + 1));
		if (sel < 75 && recent_ports.size() != 0)
			return recent_ports[$urandom_range(recent_ports.size() - 1)];
		return PORT_W'($urandom);
	endfunction

	// Offer one item; valid stays high after acceptance until the next call
	task automatic send_req(input logic [KIND_W-1:0] kind, input logic [PORT_W-1:0] port);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= port;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(allocate_outcome(kind, port));
	endtask

	// Drop valid and wait for every outstanding result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Program both range registers while idle
	task automatic set_range(input logic [PORT_W-1:0] lo_port, input logic [PORT_W-1:0] hi_port);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FIRST;
		cfg_data  <= lo_port;
		do @(posedge clk); while (!cfg_ready);
		eph_first = lo_port;
		cfg_index <= CFG_LAST;
		cfg_data  <= hi_port;
		do @(posedge clk); while (!cfg_ready);
		eph_last = hi_port;
		cfg_valid <= 1'b0;
	endtask

	// Port zero, bind/unbind at the top port, default-range ephemeral
	task automatic test_basic_requests();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		send_req(KIND_LOOKUP, 16'd0);
		send_req(KIND_ALLOC, 16'd0);
		send_req(KIND_FREE, 16'd0);
		send_req(KIND_ALLOC, 16'hFFFF);
		send_req(KIND_ALLOC, 16'hFFFF);
		send_req(KIND_LOOKUP, 16'hFFFF);
		send_req(KIND_ALLOC, FIRST_RESET);
		send_req(KIND_EPHEM, 16'hFFFF);
		send_req(KIND_FREE, 16'hFFFF);
		send_req(KIND_LOOKUP, 16'hFFFF);
		send_req(KIND_FREE, 16'd12345);
		send_req(KIND_ALLOC, 16'd1);
		send_req(KIND_LOOKUP, 16'd1);
		send_req(KIND_LOOKUP, 16'h8000);
	endtask

	// Wrap, full range, cursor outside range, inverted and extreme ranges
	task automatic test_ephemeral_ranges();
		set_range(16'd5, 16'd7);
		repeat (4) send_req(KIND_EPHEM, 16'd0);
		send_req(KIND_FREE, 16'd6);
		send_req(KIND_EPHEM, 16'd0);
		set_range(16'd100, 16'd101);
		send_req(KIND_EPHEM, 16'h5A5A);
		set_range(16'd10, 16'd9);
		send_req(KIND_EPHEM, 16'd0);
		set_range(16'hFFFF, 16'hFFFF);
		send_req(KIND_EPHEM, 16'd0);
		send_req(KIND_EPHEM, 16'd0);
		set_range(16'd1, 16'hFFFF);
		send_req(KIND_EPHEM, 16'd0);
		send_req(KIND_EPHEM, 16'd0);
	endtask

	// Mixed traffic over one range with given idle and stall rates
	task automatic test_random_traffic(input logic [PORT_W-1:0] lo_port,
			input logic [PORT_W-1:0] hi_port, input int n, input int idle_pct,
			input int stall_pct);
		int sel;
		set_range(lo_port, hi_port);
		send_idle_pct = idle_pct;
		recv_stall_pct <= stall_pct;
		repeat (n) begin
			sel = $urandom_range(99);
			if (sel < 35)
				send_req(KIND_EPHEM, PORT_W'($urandom));
			else if (sel < 60)
				send_req(KIND_ALLOC, pick_port());
			else if (sel < 85)
				send_req(KIND_FREE, pick_port());
			else
				send_req(KIND_LOOKUP, pick_port());
		end
	endtask

	// Long output hold while items keep coming
	task automatic test_output_hold();
		settle();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		hold_seq <= hold_seq + 1;
		repeat (40) send_req(KIND_EPHEM, 16'd0);
	endtask

	// Receiver: random stalls, plus a counted hold on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		alloc_result_t want;
		alloc_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status  = m_tdata[1:0];
			got.found   = m_tdata[2];
			got.granted = m_tdata[18:3];
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: unexpected result status %0d found %0d port %0d",
						$realtime, got.status, got.found, got.granted);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status || got.found != want.found ||
						got.granted != want.granted) begin
					if (mismatch_count < 10)
						$display("%0t: expected status %0d found %0d port %0d, got status %0d found %0d port %0d",
							$realtime, want.status, want.found, want.granted,
							got.status, got.found, got.granted);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= KIND_LOOKUP;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_FIRST;
		cfg_data  <= '0;
		hold_seq   = 0;
		hold_seen  = 0;
		hold_left  = 0;
		recv_stall_pct = 0;
		send_idle_pct  = 0;
		mismatch_count = 0;
		next_ephem = FIRST_RESET;
		eph_first  = FIRST_RESET;
		eph_last   = LAST_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_requests();
		test_ephemeral_ranges();
		test_random_traffic(16'd1000, 16'd1031, 380, 0, 0);
		test_random_traffic(16'd65500, 16'hFFFF, 380, 67, 0);
		test_random_traffic(16'd1, 16'd40, 380, 0, 67);
		test_random_traffic(16'd300, 16'd363, 380, 24, 24);
		test_random_traffic(16'd1, 16'hFFFF, 100, 24, 24);
		test_output_hold();

		settle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_round_robin_port_allocator_unit: clean");
		else
			$display("tb_round_robin_port_allocator_unit: errors");
		$finish;
	end

endmodule
